@@ sv/ckb_pkg.sv @@
// ----------------------------------------------------------------------------
// ckb_pkg
// Shared types, widths and helpers of the color key soft blend pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ckb_pkg;

    localparam int ROOT_FRAC_BITS = 8;
    localparam int ChanW     = 8;
    localparam int RadW      = 9;
    localparam int CfgW      = 9;
    localparam int CfgIdxW   = 3;
    localparam int AlphaW    = 8;
    localparam int D2W       = 18;                       // 3 * 255^2 fits
    localparam int VW        = D2W + 2 * ROOT_FRAC_BITS; // radicand width
    localparam int RootW     = D2W / 2 + ROOT_FRAC_BITS; // root width
    localparam int RW        = RootW + 3;                // partial remainder
    localparam int SqIters   = RootW;
    localparam int SqStages  = (SqIters + 1) / 2;
    localparam int NumW      = RootW + AlphaW;           // 255 * span
    localparam int DivStages = AlphaW / 2;
    localparam int MixW      = 2 * ChanW + 1;

    localparam logic [AlphaW-1:0] FullAlpha = 8'd255;
    localparam logic [ChanW-1:0]  KeyReset  = 8'd70;
    localparam logic [RadW-1:0]   InnerReset = 9'd60;
    localparam logic [RadW-1:0]   OuterReset = 9'd170;

    typedef enum logic [CfgIdxW-1:0] {
        REG_KEY_RED   = 3'd0,
        REG_KEY_GREEN = 3'd1,
        REG_KEY_BLUE  = 3'd2,
        REG_INNER     = 3'd3,
        REG_OUTER     = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [ChanW-1:0] fg_red;
        logic [ChanW-1:0] fg_green;
        logic [ChanW-1:0] fg_blue;
        logic [ChanW-1:0] key_src_red;
        logic [ChanW-1:0] key_src_green;
        logic [ChanW-1:0] key_src_blue;
    } pix_t;

    typedef struct packed {
        logic [ChanW-1:0]  out_red;
        logic [ChanW-1:0]  out_green;
        logic [ChanW-1:0]  out_blue;
        logic [AlphaW-1:0] alpha_used;
    } res_t;

    typedef struct packed {
        logic [ChanW-1:0] red;
        logic [ChanW-1:0] green;
        logic [ChanW-1:0] blue;
    } key_t;

    typedef struct packed {
        logic [RW-1:0]    r;
        logic [RootW-1:0] q;
    } sq_t;

    typedef struct packed {
        logic [NumW-1:0] rem;
        logic            bit_q;
    } dv_t;

    // One digit of the restoring square root.
    function automatic sq_t sqrt_step(input logic [RW-1:0] r, input logic [RootW-1:0] q,
                                      input logic [1:0] pair);
        logic [RW-1:0] rs;
        logic [RW-1:0] t;
        sq_t o;
        rs = {r[RW-3:0], pair};
        t  = {1'b0, q, 2'b01};
        if (rs >= t)
        begin
            o.r = rs - t;
            o.q = {q[RootW-2:0], 1'b1};
        end
        else
        begin
            o.r = rs;
            o.q = {q[RootW-2:0], 1'b0};
        end
        return o;
    endfunction

    // One quotient bit of the restoring divider; dsh is the shifted divisor.
    function automatic dv_t div_step(input logic [NumW-1:0] rem, input logic [NumW-1:0] dsh);
        dv_t o;
        if (rem >= dsh)
        begin
            o.rem   = rem - dsh;
            o.bit_q = 1'b1;
        end
        else
        begin
            o.rem   = rem;
            o.bit_q = 1'b0;
        end
        return o;
    endfunction

endpackage

`default_nettype wire

@@ sv/ckb_dist.sv @@
// ----------------------------------------------------------------------------
// ckb_dist
// Squared distance of the key source pixel from the key color, two stages.
// ----------------------------------------------------------------------------
`default_nettype none

module ckb_dist (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire ckb_pkg::pix_t        in_pix,
    input  wire ckb_pkg::key_t        key,
    output logic                      out_valid,
    output ckb_pkg::pix_t             out_pix,
    output logic [ckb_pkg::D2W-1:0]   out_d2
);
    import ckb_pkg::*;

    logic               s1_valid_reg;
    pix_t               s1_pix_reg;
    logic [2*ChanW-1:0] sq_r_reg, sq_g_reg, sq_b_reg;
    logic [2*ChanW-1:0] sq_r_next, sq_g_next, sq_b_next;
    logic               s2_valid_reg;
    pix_t               s2_pix_reg;
    logic [D2W-1:0]     d2_reg;
    logic [D2W-1:0]     d2_next;
    logic [ChanW-1:0]   dr, dg, db;

    always_comb
    begin
        dr = (in_pix.key_src_red >= key.red) ? in_pix.key_src_red - key.red
                                             : key.red - in_pix.key_src_red;
        dg = (in_pix.key_src_green >= key.green) ? in_pix.key_src_green - key.green
                                                 : key.green - in_pix.key_src_green;
        db = (in_pix.key_src_blue >= key.blue) ? in_pix.key_src_blue - key.blue
                                               : key.blue - in_pix.key_src_blue;
        sq_r_next = dr * dr;
        sq_g_next = dg * dg;
        sq_b_next = db * db;
        d2_next = D2W'(sq_r_reg) + D2W'(sq_g_reg) + D2W'(sq_b_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_pix_reg <= in_pix;
            sq_r_reg   <= sq_r_next;
            sq_g_reg   <= sq_g_next;
            sq_b_reg   <= sq_b_next;
            s2_pix_reg <= s1_pix_reg;
            d2_reg     <= d2_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_pix   = s2_pix_reg;
    assign out_d2    = d2_reg;

endmodule

`default_nettype wire

@@ sv/ckb_sqrt.sv @@
// ----------------------------------------------------------------------------
// ckb_sqrt
// Pipelined fixed-point square root, two digits per stage and one in the last stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ckb_sqrt (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic                  in_valid,
    input  wire ckb_pkg::pix_t         in_pix,
    input  wire logic [ckb_pkg::D2W-1:0] in_d2,
    output logic                       out_valid,
    output ckb_pkg::pix_t              out_pix,
    output logic [ckb_pkg::RootW-1:0]  out_root
);
    import ckb_pkg::*;

    logic             valid_reg [SqStages];
    pix_t             pix_reg   [SqStages];
    logic [VW-1:0]    v_reg     [SqStages];
    sq_t              sq_reg    [SqStages];

    genvar s;
    generate
        for (s = 0; s < SqStages; s++)
        begin : g_stage
            logic          v_in;
            pix_t          p_in;
            logic [VW-1:0] rad_in;
            sq_t           sq_in;
            sq_t           sq_mid;
            sq_t           sq_next;

            if (s == 0)
            begin : g_first
                assign v_in   = in_valid;
                assign p_in   = in_pix;
                assign rad_in = {in_d2, (2 * ROOT_FRAC_BITS)'(0)};
                assign sq_in  = '0;
            end
            else
            begin : g_rest
                assign v_in   = valid_reg[s-1];
                assign p_in   = pix_reg[s-1];
                assign rad_in = v_reg[s-1];
                assign sq_in  = sq_reg[s-1];
            end

            assign sq_mid = sqrt_step(sq_in.r, sq_in.q,
                                      rad_in[2*(SqIters-1-2*s)+1 -: 2]);
            if (2 * s + 1 < SqIters)
            begin : g_two
                assign sq_next = sqrt_step(sq_mid.r, sq_mid.q,
                                           rad_in[2*(SqIters-2-2*s)+1 -: 2]);
            end
            else
            begin : g_one
                assign sq_next = sq_mid;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[s] <= 1'b0;
                else if (en)
                    valid_reg[s] <= v_in;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    pix_reg[s] <= p_in;
                    v_reg[s]   <= rad_in;
                    sq_reg[s]  <= sq_next;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[SqStages-1];
    assign out_pix   = pix_reg[SqStages-1];
    assign out_root  = sq_reg[SqStages-1].q;

endmodule

`default_nettype wire

@@ sv/ckb_alpha.sv @@
// ----------------------------------------------------------------------------
// ckb_alpha
// Alpha from the distance: radius tests, then a pipelined ramp divider.
// ----------------------------------------------------------------------------
`default_nettype none

module ckb_alpha (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    en,
    input  wire logic                    in_valid,
    input  wire ckb_pkg::pix_t           in_pix,
    input  wire logic [ckb_pkg::RootW-1:0] in_root,
    input  wire logic [ckb_pkg::RadW-1:0]  inner,
    input  wire logic [ckb_pkg::RadW-1:0]  outer,
    output logic                         out_valid,
    output ckb_pkg::pix_t                out_pix,
    output logic [ckb_pkg::AlphaW-1:0]   out_alpha
);
    import ckb_pkg::*;

    localparam int NS = DivStages + 1;

    logic              valid_reg [NS];
    pix_t              pix_reg   [NS];
    logic              full_reg  [NS];
    logic              zero_reg  [NS];
    logic [NumW-1:0]   rem_reg   [NS];
    logic [RootW-1:0]  den_reg   [NS];
    logic [AlphaW-1:0] quot_reg  [NS];

    logic [RootW-1:0] in_fx, out_fx, span;
    logic [NumW-1:0]  num_next;

    always_comb
    begin
        in_fx    = RootW'(inner) << ROOT_FRAC_BITS;
        out_fx   = RootW'(outer) << ROOT_FRAC_BITS;
        span     = out_fx - in_root;
        num_next = (NumW'(span) << AlphaW) - NumW'(span);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pix_reg[0]  <= in_pix;
            full_reg[0] <= (in_root <= in_fx);
            zero_reg[0] <= (in_root >= out_fx);
            rem_reg[0]  <= num_next;
            den_reg[0]  <= out_fx - in_fx;
            quot_reg[0] <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg[0] <= 1'b0;
        else if (en)
            valid_reg[0] <= in_valid;
    end

    genvar s;
    generate
        for (s = 1; s < NS; s++)
        begin : g_div
            dv_t d_hi, d_lo;

            assign d_hi = div_step(rem_reg[s-1],
                                   NumW'(den_reg[s-1]) << (AlphaW - 2 * s + 1));
            assign d_lo = div_step(d_hi.rem,
                                   NumW'(den_reg[s-1]) << (AlphaW - 2 * s));

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[s] <= 1'b0;
                else if (en)
                    valid_reg[s] <= valid_reg[s-1];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    pix_reg[s]  <= pix_reg[s-1];
                    full_reg[s] <= full_reg[s-1];
                    zero_reg[s] <= zero_reg[s-1];
                    rem_reg[s]  <= d_lo.rem;
                    den_reg[s]  <= den_reg[s-1];
                    quot_reg[s] <= {quot_reg[s-1][AlphaW-3:0], d_hi.bit_q, d_lo.bit_q};
                end
            end
        end
    endgenerate

    // inner test wins over outer test when the radii are inverted
    always_comb
    begin
        if (full_reg[NS-1])
            out_alpha = FullAlpha;
        else if (zero_reg[NS-1])
            out_alpha = '0;
        else
            out_alpha = quot_reg[NS-1];
    end

    assign out_valid = valid_reg[NS-1];
    assign out_pix   = pix_reg[NS-1];

endmodule

`default_nettype wire

@@ sv/color_key_soft_blend.sv @@
// ----------------------------------------------------------------------------
// color_key_soft_blend
// Chroma key with a soft alpha ramp and per-channel blend, fully pipelined.
//
//   channel  signals                          width        role
//   pix      pix_valid pix_ready pix          48 (struct)  pixel pair request
//   res      res_valid res_ready res          32 (struct)  blended pixel
//   cfg      cfg_we cfg_index cfg_data        3 / 9        register write
//
// One request per cycle sustained while res is not stalled; the stages are 2 distance
// stages, 9 square root stages (two root digits each, one in the last), 5 alpha
// stages (test plus a divider of two quotient bits per stage) and 2 blend stages.
// Reset clears all valid bits and loads the key and radius registers.
// A stall at res holds every stage; no request is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module color_key_soft_blend (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      pix_valid,
    output logic                           pix_ready,
    input  wire ckb_pkg::pix_t             pix,
    output logic                           res_valid,
    input  wire logic                      res_ready,
    output ckb_pkg::res_t                  res,
    input  wire logic                      cfg_we,
    input  wire logic [ckb_pkg::CfgIdxW-1:0] cfg_index,
    input  wire logic [ckb_pkg::CfgW-1:0]  cfg_data
);
    import ckb_pkg::*;

    key_t            key_reg;
    logic [RadW-1:0] inner_reg, outer_reg;

    logic              en;
    logic              d_valid, s_valid, a_valid;
    pix_t              d_pix, s_pix, a_pix;
    logic [D2W-1:0]    d_d2;
    logic [RootW-1:0]  s_root;
    logic [AlphaW-1:0] a_alpha;

    logic              m_valid_reg;
    logic [MixW-1:0]   m_r_reg, m_g_reg, m_b_reg;
    logic [MixW-1:0]   m_r_next, m_g_next, m_b_next;
    logic [AlphaW-1:0] m_alpha_reg;
    logic              res_valid_reg;
    res_t              res_reg;
    res_t              res_next;

    assign en        = !res_valid_reg || res_ready;
    assign pix_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg   <= '{red: KeyReset, green: KeyReset, blue: KeyReset};
            inner_reg <= InnerReset;
            outer_reg <= OuterReset;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_KEY_RED:   key_reg.red   <= cfg_data[ChanW-1:0];
                REG_KEY_GREEN: key_reg.green <= cfg_data[ChanW-1:0];
                REG_KEY_BLUE:  key_reg.blue  <= cfg_data[ChanW-1:0];
                REG_INNER:     inner_reg     <= cfg_data[RadW-1:0];
                REG_OUTER:     outer_reg     <= cfg_data[RadW-1:0];
                default:       ;
            endcase
        end
    end

    ckb_dist u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pix_valid),
        .in_pix    (pix),
        .key       (key_reg),
        .out_valid (d_valid),
        .out_pix   (d_pix),
        .out_d2    (d_d2)
    );

    ckb_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (d_valid),
        .in_pix    (d_pix),
        .in_d2     (d_d2),
        .out_valid (s_valid),
        .out_pix   (s_pix),
        .out_root  (s_root)
    );

    ckb_alpha u_alpha (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_valid),
        .in_pix    (s_pix),
        .in_root   (s_root),
        .inner     (inner_reg),
        .outer     (outer_reg),
        .out_valid (a_valid),
        .out_pix   (a_pix),
        .out_alpha (a_alpha)
    );

    always_comb
    begin
        m_r_next = MixW'(a_pix.fg_red) * MixW'(a_alpha)
                 + MixW'(a_pix.key_src_red) * MixW'(FullAlpha - a_alpha);
        m_g_next = MixW'(a_pix.fg_green) * MixW'(a_alpha)
                 + MixW'(a_pix.key_src_green) * MixW'(FullAlpha - a_alpha);
        m_b_next = MixW'(a_pix.fg_blue) * MixW'(a_alpha)
                 + MixW'(a_pix.key_src_blue) * MixW'(FullAlpha - a_alpha);
    end

    // divide by 255 as (x + (x >> 8) + 1) >> 8, exact over the blend range
    function automatic logic [ChanW-1:0] div255(input logic [MixW-1:0] x);
        logic [MixW:0] t;
        t = {1'b0, x} + (MixW + 1)'(x >> 8) + (MixW + 1)'(1);
        t = t >> 8;
        return (t > (MixW + 1)'(FullAlpha)) ? FullAlpha : t[ChanW-1:0];
    endfunction

    always_comb
    begin
        res_next.out_red    = div255(m_r_reg);
        res_next.out_green  = div255(m_g_reg);
        res_next.out_blue   = div255(m_b_reg);
        res_next.alpha_used = m_alpha_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_valid_reg   <= a_valid;
            res_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_r_reg     <= m_r_next;
            m_g_reg     <= m_g_next;
            m_b_reg     <= m_b_next;
            m_alpha_reg <= a_alpha;
            res_reg     <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // hold the whole pipe exactly while a result waits
    a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
        pix_ready == (!res_valid || res_ready))
        else $error("pix_ready does not follow the output stall");

    // inverted radii leave only the hard alpha values
    a_inverted_radii: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (inner_reg >= outer_reg))
        |-> (res.alpha_used == FullAlpha || res.alpha_used == '0))
        else $error("ramp alpha seen with inverted radii");

    // a result nobody took is still there next cycle
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res)))
        else $error("pending result lost during stall");

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for color_key_soft_blend: a bit-exact blend predictor
// fills an expected-pixel queue for every accepted request, and a monitor
// compares each accepted result field by field. Directed extremes come first,
// then random pixels under several key and radius settings, with random
// idling on both sides, one long output hold-off and one drain pause.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ckb_pkg::*;

    localparam int LATENCY = 18;

    logic clk;
    logic rst_n;
    logic pix_valid;
    logic pix_ready;
    pix_t pix;
    logic res_valid;
    logic res_ready;
    res_t res;
    logic cfg_we;
    logic [CfgIdxW-1:0] cfg_index;
    logic [CfgW-1:0] cfg_data;

    color_key_soft_blend u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor copy of the registers
    logic [7:0] key_r, key_g, key_b;
    logic [8:0] inner_rad, outer_rad;

    res_t blend_queue[$];
    int   mismatches;
    int   hold_off;
    bit   drain_busy;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic [31:0] root_fx(input logic [33:0] v);
        logic [33:0] rem;
        logic [33:0] acc;
        logic [33:0] bitv;
        rem  = v;
        acc  = '0;
        bitv = 34'd1 << 32;
        while (bitv != 0)
        begin
            if (rem >= acc + bitv)
            begin
                rem = rem - (acc + bitv);
                acc = (acc >> 1) + bitv;
            end
            else
                acc = acc >> 1;
            bitv = bitv >> 2;
        end
        return acc[31:0];
    endfunction

    function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    function automatic res_t predict_blend(input pix_t p);
        logic [7:0]  dr, dg, db;
        logic [33:0] d2;
        logic [31:0] q, in_fx, out_fx;
        logic [7:0]  a;
        logic [31:0] vr, vg, vb;
        res_t o;
        dr = abs_diff(p.key_src_red, key_r);
        dg = abs_diff(p.key_src_green, key_g);
        db = abs_diff(p.key_src_blue, key_b);
        d2 = 34'(dr) * dr + 34'(dg) * dg + 34'(db) * db;
        q = root_fx(d2 << (2 * ROOT_FRAC_BITS));
        in_fx  = 32'(inner_rad) << ROOT_FRAC_BITS;
        out_fx = 32'(outer_rad) << ROOT_FRAC_BITS;
        if (q <= in_fx)
            a = 8'd255;
        else if (q >= out_fx)
            a = 8'd0;
        else
            a = 8'((32'd255 * (out_fx - q)) / (out_fx - in_fx));
        vr = (32'(p.fg_red) * a + (32'd255 - a) * p.key_src_red) / 32'd255;
        vg = (32'(p.fg_green) * a + (32'd255 - a) * p.key_src_green) / 32'd255;
        vb = (32'(p.fg_blue) * a + (32'd255 - a) * p.key_src_blue) / 32'd255;
        o.out_red    = (vr > 255) ? 8'd255 : vr[7:0];
        o.out_green  = (vg > 255) ? 8'd255 : vg[7:0];
        o.out_blue   = (vb > 255) ? 8'd255 : vb[7:0];
        o.alpha_used = a;
        return o;
    endfunction

    // One write, then cfg_we drops before the next write, so back-to-back writes never collide
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_KEY_RED:   key_r = val[7:0];
            REG_KEY_GREEN: key_g = val[7:0];
            REG_KEY_BLUE:  key_b = val[7:0];
            REG_INNER:     inner_rad = val;
            REG_OUTER:     outer_rad = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_key(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                           input logic [8:0] inr, input logic [8:0] outr);
        write_reg(REG_KEY_RED, {1'b0, r});
        write_reg(REG_KEY_GREEN, {1'b0, g});
        write_reg(REG_KEY_BLUE, {1'b0, b});
        write_reg(REG_INNER, inr);
        write_reg(REG_OUTER, outr);
    endtask

    task automatic wait_drain();
        pix_valid <= 1'b0;
        while (blend_queue.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // Send one pixel pair; the gap is drawn before valid goes up.
    // Valid stays high after the accept until the next gap or drain.
    task automatic send_pixel(input pix_t p, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            pix_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix       <= p;
        @(posedge clk);
        while (!pix_ready)
            @(posedge clk);
        blend_queue.push_back(predict_blend(p));
    endtask

    function automatic pix_t rand_pixel();
        pix_t p;
        p = pix_t'(48'({$urandom, $urandom}));
        return p;
    endfunction

    // Key-source near the key so the soft ramp is exercised
    function automatic pix_t near_pixel();
        pix_t p;
        int span;
        p = rand_pixel();
        span = $urandom_range(0, 150);
        p.key_src_red   = 8'(int'(key_r) + $urandom_range(0, 2 * span) - span);
        p.key_src_green = 8'(int'(key_g) + $urandom_range(0, 2 * span) - span);
        p.key_src_blue  = 8'(int'(key_b) + $urandom_range(0, 2 * span) - span);
        return p;
    endfunction

    task automatic test_directed();
        pix_t p;
        send_pixel('0, 1'b0);
        send_pixel('1, 1'b0);
        p = '0;
        p.fg_red = 8'd255; p.fg_green = 8'd255; p.fg_blue = 8'd255;
        p.key_src_red = 8'd70; p.key_src_green = 8'd70; p.key_src_blue = 8'd70;
        send_pixel(p, 1'b0);
        // exactly at the inner radius, and just above it
        p.key_src_red = 8'd130;
        send_pixel(p, 1'b0);
        p.key_src_green = 8'd71;
        send_pixel(p, 1'b0);
        // at the outer radius and mid ramp
        p.key_src_red = 8'd240; p.key_src_green = 8'd70;
        send_pixel(p, 1'b0);
        p.key_src_red = 8'd175;
        send_pixel(p, 1'b0);
        p.key_src_red = 8'd0; p.key_src_green = 8'd255; p.key_src_blue = 8'd0;
        send_pixel(p, 1'b0);
        wait_drain();
        // inverted radii, zero radii, oversized radii, extreme keys
        set_key(8'd0, 8'd0, 8'd0, 9'd200, 9'd100);
        send_pixel('0, 1'b0);
        send_pixel('1, 1'b0);
        p = '0; p.key_src_red = 8'd150;
        send_pixel(p, 1'b0);
        p.key_src_red = 8'd220;
        send_pixel(p, 1'b0);
        wait_drain();
        set_key(8'd255, 8'd255, 8'd255, 9'd0, 9'd0);
        send_pixel('1, 1'b0);
        send_pixel('0, 1'b0);
        wait_drain();
        set_key(8'd255, 8'd0, 8'd255, 9'd511, 9'd511);
        send_pixel('0, 1'b0);
        send_pixel('1, 1'b0);
        wait_drain();
        set_key(8'd128, 8'd128, 8'd128, 9'd0, 9'd442);
        send_pixel('0, 1'b0);
        send_pixel('1, 1'b0);
        wait_drain();
        // unknown register indexes are ignored
        write_reg(3'd7, 9'h1FF);
        write_reg(3'd5, 9'h0);
        send_pixel(rand_pixel(), 1'b0);
        wait_drain();
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
            send_pixel(($urandom_range(0, 3) == 0) ? rand_pixel() : near_pixel(),
                       ($urandom_range(0, 4) == 0));
        wait_drain();
    endtask

    task automatic test_configs();
        for (int c = 0; c < 6; c++)
        begin
            logic [8:0] a, b;
            a = 9'($urandom_range(0, 300));
            b = 9'($urandom_range(0, 442));
            set_key(8'($urandom), 8'($urandom), 8'($urandom), a, b);
            test_random(150);
        end
    endtask

    task automatic test_backpressure();
        set_key(8'd70, 8'd70, 8'd70, 9'd60, 9'd170);
        hold_off = 200;
        for (int i = 0; i < 60; i++)
            send_pixel(near_pixel(), 1'b1);
        wait_drain();
        // pause until everything has come out, then resume back to back
        for (int i = 0; i < 40; i++)
            send_pixel(near_pixel(), 1'b1);
        wait_drain();
    endtask

    // Output ready: random stalls per result, plus the long hold-off
    initial
    begin
        int stall;
        res_ready = 1'b0;
        hold_off  = 0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off > 0)
            begin
                res_ready <= 1'b0;
                repeat (hold_off) @(posedge clk);
                hold_off = 0;
            end
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            if ($urandom_range(0, 2) == 0)
                stall = 0;
            if (stall > 0)
            begin
                res_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ready <= 1'b1;
            @(posedge clk);
            while (!res_valid)
                @(posedge clk);
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        res_t exp_res;
        if (rst_n && res_valid && res_ready)
        begin
            if (blend_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", res);
            end
            else
            begin
                exp_res = blend_queue.pop_front();
                if (res !== exp_res)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: exp r%0d g%0d b%0d a%0d got r%0d g%0d b%0d a%0d",
                                 exp_res.out_red, exp_res.out_green, exp_res.out_blue,
                                 exp_res.alpha_used, res.out_red, res.out_green,
                                 res.out_blue, res.alpha_used);
                end
            end
        end
    end

    initial
    begin
        mismatches = 0;
        rst_n      = 1'b0;
        pix_valid  = 1'b0;
        pix        = '0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        key_r = KeyReset; key_g = KeyReset; key_b = KeyReset;
        inner_rad = InnerReset; outer_rad = OuterReset;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(100);
        test_configs();
        test_backpressure();
        wait_drain();
        if (mismatches == 0 && blend_queue.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
